// File: design/ppmfd_pkg.sv
// ppmfd_pkg: shared types, constants and register codes for the ppm frame decoder
// no dependencies; imported by ppmfd_frame_eval and ppm_frame_decoder
package ppmfd_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int WIDTH_W      = 16;
   localparam int CHAN_IDX_W   = 4;
   localparam int CHAN_SEL_W   = $clog2(NUM_CHANNELS);
   localparam int CSR_IDX_W    = 3;
   localparam int POS_W        = 2;
   localparam int MODE_W       = 3;
   localparam int ZONE_W       = 4;
   localparam int REQ_DATA_W   = 16;
   localparam int RSP_DATA_W   = 88;
   localparam int RSP_FIELDS_W = 4 * WIDTH_W + 2 * POS_W + MODE_W + 2 * ZONE_W + 2;

   // channel counter codes
   localparam logic [CHAN_IDX_W-1:0] CHAN_FIRST = CHAN_IDX_W'(0);
   localparam logic [CHAN_IDX_W-1:0] CHAN_LAST  = CHAN_IDX_W'(NUM_CHANNELS - 1);
   localparam logic [CHAN_IDX_W-1:0] CHAN_IDLE  = CHAN_IDX_W'(NUM_CHANNELS + 1);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SYNC_GAP    = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_SWITCH_LOW  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_SWITCH_HIGH = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_STICK_LOW   = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_STICK_HIGH  = CSR_IDX_W'(4);

   // register reset values
   localparam logic [WIDTH_W-1:0] SYNC_GAP_RST    = WIDTH_W'(3000);
   localparam logic [WIDTH_W-1:0] SWITCH_LOW_RST  = WIDTH_W'(1300);
   localparam logic [WIDTH_W-1:0] SWITCH_HIGH_RST = WIDTH_W'(1700);
   localparam logic [WIDTH_W-1:0] STICK_LOW_RST   = WIDTH_W'(1200);
   localparam logic [WIDTH_W-1:0] STICK_HIGH_RST  = WIDTH_W'(1800);

   // switch positions
   localparam logic [POS_W-1:0] POS_UP   = POS_W'(0);
   localparam logic [POS_W-1:0] POS_MID  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_DOWN = POS_W'(2);

   // drive modes from switches a and d
   localparam logic [MODE_W-1:0] MODE_NONE      = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_UP_UP     = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_UP_DOWN   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_DOWN_UP   = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_DOWN_DOWN = MODE_W'(4);

   typedef struct packed {
      logic [WIDTH_W-1:0] sync_gap;
      logic [WIDTH_W-1:0] switch_low;
      logic [WIDTH_W-1:0] switch_high;
      logic [WIDTH_W-1:0] stick_low;
      logic [WIDTH_W-1:0] stick_high;
   } cfg_type;

   typedef struct packed {
      logic             armed;
      logic [POS_W-1:0] prev_b;
      logic [POS_W-1:0] prev_c;
   } fire_state_type;

   typedef struct packed {
      logic [WIDTH_W-1:0] stick_a_x;
      logic [WIDTH_W-1:0] stick_a_y;
      logic [WIDTH_W-1:0] stick_b_x;
      logic [WIDTH_W-1:0] stick_b_y;
      logic [POS_W-1:0]   switch_b_pos;
      logic [POS_W-1:0]   switch_c_pos;
      logic [MODE_W-1:0]  drive_mode;
      logic [ZONE_W-1:0]  zone_a;
      logic [ZONE_W-1:0]  zone_b;
      logic               fire_left;
      logic               fire_right;
   } frame_type;

   typedef logic [WIDTH_W-1:0] width_array_type [NUM_CHANNELS];

endpackage

// File: design/ppmfd_frame_eval.sv
// ppmfd_frame_eval: turns one frame of channel widths into a frame result
// and the next fire-detect state; uses ppmfd_pkg
module ppmfd_frame_eval (
   input  ppmfd_pkg::width_array_type width_in,
   input  ppmfd_pkg::cfg_type         cfg_in,
   input  ppmfd_pkg::fire_state_type  fire_state_in,
   output ppmfd_pkg::frame_type       frame_out,
   output ppmfd_pkg::fire_state_type  fire_state_out
);
   import ppmfd_pkg::*;

   logic [POS_W-1:0]  pos_a;
   logic [POS_W-1:0]  pos_b;
   logic [POS_W-1:0]  pos_c;
   logic [POS_W-1:0]  pos_d;
   logic [MODE_W-1:0] mode;
   logic [POS_W-1:0]  prev_b;
   logic [POS_W-1:0]  prev_c;

   function automatic logic [POS_W-1:0] switch_pos(input logic [WIDTH_W-1:0] w,
                                                   input cfg_type c);
      logic [POS_W-1:0] p;
      if (w < c.switch_low) begin
         p = POS_UP;
      end else if (w > c.switch_high) begin
         p = POS_DOWN;
      end else begin
         p = POS_MID;
      end
      return p;
   endfunction

   // 3*h + v, low side tested first horizontally, top side first vertically
   function automatic logic [ZONE_W-1:0] stick_zone(input logic [WIDTH_W-1:0] x,
                                                    input logic [WIDTH_W-1:0] y,
                                                    input cfg_type c);
      logic [1:0] h;
      logic [1:0] v;
      if (x < c.stick_low) begin
         h = 2'd0;
      end else if (x > c.stick_high) begin
         h = 2'd2;
      end else begin
         h = 2'd1;
      end
      if (y > c.stick_high) begin
         v = 2'd0;
      end else if (y < c.stick_low) begin
         v = 2'd2;
      end else begin
         v = 2'd1;
      end
      return ZONE_W'({h, 1'b0}) + ZONE_W'(h) + ZONE_W'(v);
   endfunction

   assign pos_a = switch_pos(width_in[4], cfg_in);
   assign pos_b = switch_pos(width_in[5], cfg_in);
   assign pos_c = switch_pos(width_in[6], cfg_in);
   assign pos_d = switch_pos(width_in[7], cfg_in);

   always_comb begin
      if (pos_a == POS_UP && pos_d == POS_UP) begin
         mode = MODE_UP_UP;
      end else if (pos_a == POS_UP && pos_d == POS_DOWN) begin
         mode = MODE_UP_DOWN;
      end else if (pos_a == POS_DOWN && pos_d == POS_UP) begin
         mode = MODE_DOWN_UP;
      end else if (pos_a == POS_DOWN && pos_d == POS_DOWN) begin
         mode = MODE_DOWN_DOWN;
      end else begin
         mode = MODE_NONE;
      end
   end

   // on entry to the fire mode the previous positions are taken as current
   assign prev_b = fire_state_in.armed ? fire_state_in.prev_b : pos_b;
   assign prev_c = fire_state_in.armed ? fire_state_in.prev_c : pos_c;

   always_comb begin
      fire_state_out = fire_state_in;
      if (mode == MODE_UP_DOWN) begin
         fire_state_out.armed  = 1'b1;
         fire_state_out.prev_b = pos_b;
         fire_state_out.prev_c = pos_c;
      end else if (mode != MODE_NONE) begin
         fire_state_out.armed = 1'b0;
      end
   end

   always_comb begin
      frame_out.stick_a_x    = width_in[0];
      frame_out.stick_a_y    = width_in[1];
      frame_out.stick_b_x    = width_in[3];
      frame_out.stick_b_y    = width_in[2];
      frame_out.switch_b_pos = pos_b;
      frame_out.switch_c_pos = pos_c;
      frame_out.drive_mode   = mode;
      frame_out.zone_a       = stick_zone(width_in[0], width_in[1], cfg_in);
      frame_out.zone_b       = stick_zone(width_in[3], width_in[2], cfg_in);
      frame_out.fire_left    = (mode == MODE_UP_DOWN) && (pos_b != prev_b);
      frame_out.fire_right   = (mode == MODE_UP_DOWN) && (pos_c != prev_c);
   end

endmodule

// File: design/ppm_frame_decoder.sv
// ppm_frame_decoder: top level of the rc ppm pulse-train decoder
// uses ppmfd_pkg and ppmfd_frame_eval
//
// Each req beat carries one rising-edge timestamp from a free-running 16-bit
// timer. The decoder takes the wrapped difference to the previous edge; a
// difference above sync_gap marks frame sync, and the next eight differences
// are the channel widths. The eighth one produces one rsp beat with the four
// stick widths (received channels 2 and 3 swapped), switch b and c positions,
// the drive mode from switches a and d, the nine-way zone of each stick and
// the fire flags, which pulse in drive mode 2 when switch b or c moves. Edges
// past the eighth channel are dropped until the next sync; the very first
// edge after reset only seeds the timer reference. One edge is accepted every
// cycle while no result waits on rsp_tready: the timestamp lands in an input
// register, the difference, channel bookkeeping and frame evaluation are a
// single combinational pass, and the frame lands in the result register, so
// rsp_tvalid rises once the last edge of a frame has passed both registers.
// While a result waits on rsp_tready, one more edge is held in the input
// register before req_tready drops. The user must write registers through the
// csr port only while the decoder is idle; the decoder does not enforce this.
module ppm_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ppmfd_pkg::REQ_DATA_W-1:0]    req_tdata,  // [15:0] edge_time
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] stick_a_x, [31:16] stick_a_y, [47:32] stick_b_x, [63:48] stick_b_y,
   // [65:64] switch_b_pos, [67:66] switch_c_pos, [70:68] drive_mode,
   // [74:71] zone_a, [78:75] zone_b, [79] fire_left, [80] fire_right, rest zero
   output logic [ppmfd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_we,
   input  logic [ppmfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ppmfd_pkg::WIDTH_W-1:0]       csr_wdata
);
   import ppmfd_pkg::*;

   // configuration
   cfg_type cfg_ff;
   cfg_type cfg_in;

   // input register
   logic               in_valid_ff;
   logic               in_valid_in;
   logic [WIDTH_W-1:0] edge_ff;

   // decoder state
   logic [WIDTH_W-1:0]    last_edge_ff;
   logic                  have_last_ff;
   logic [CHAN_IDX_W-1:0] chan_index_ff;
   logic [CHAN_IDX_W-1:0] chan_index_in;
   logic [WIDTH_W-1:0]    widths_ff [NUM_CHANNELS];
   fire_state_type        fire_state_ff;
   fire_state_type        fire_state_in;
   fire_state_type        fire_state_eval;

   // result register
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   frame_type frame_ff;
   frame_type frame_eval;

   logic               stage_fire;
   logic [WIDTH_W-1:0] diff;
   logic               is_sync;
   logic               chan_write;
   logic               frame_done;
   width_array_type    frame_widths;

   // the input register advances whenever the result register can take a frame
   assign stage_fire = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_fire;

   assign diff       = edge_ff - last_edge_ff;
   assign is_sync    = have_last_ff && (diff > cfg_ff.sync_gap);
   assign chan_write = have_last_ff && !is_sync && !chan_index_ff[CHAN_IDX_W-1];
   assign frame_done = chan_write && (chan_index_ff == CHAN_LAST);

   // the last channel comes straight from the difference
   always_comb begin
      for (int i = 0; i < NUM_CHANNELS - 1; i++) begin
         frame_widths[i] = widths_ff[i];
      end
      frame_widths[NUM_CHANNELS-1] = diff;
   end

   ppmfd_frame_eval u_eval (
      .width_in       (frame_widths),
      .cfg_in         (cfg_ff),
      .fire_state_in  (fire_state_ff),
      .frame_out      (frame_eval),
      .fire_state_out (fire_state_eval)
   );

   // channel counter: sync restarts, the last channel parks it idle
   always_comb begin
      chan_index_in = chan_index_ff;
      if (stage_fire) begin
         if (is_sync) begin
            chan_index_in = CHAN_FIRST;
         end else if (frame_done) begin
            chan_index_in = CHAN_IDLE;
         end else if (chan_write) begin
            chan_index_in = chan_index_ff + CHAN_IDX_W'(1);
         end
      end
   end

   assign fire_state_in = (stage_fire && frame_done) ? fire_state_eval : fire_state_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (stage_fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (stage_fire && frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SYNC_GAP:    cfg_in.sync_gap    = csr_wdata;
            REG_SWITCH_LOW:  cfg_in.switch_low  = csr_wdata;
            REG_SWITCH_HIGH: cfg_in.switch_high = csr_wdata;
            REG_STICK_LOW:   cfg_in.stick_low   = csr_wdata;
            REG_STICK_HIGH:  cfg_in.stick_high  = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_gap    <= SYNC_GAP_RST;
         cfg_ff.switch_low  <= SWITCH_LOW_RST;
         cfg_ff.switch_high <= SWITCH_HIGH_RST;
         cfg_ff.stick_low   <= STICK_LOW_RST;
         cfg_ff.stick_high  <= STICK_HIGH_RST;
         in_valid_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
         last_edge_ff       <= '0;
         have_last_ff       <= 1'b0;
         chan_index_ff      <= CHAN_IDLE;
         fire_state_ff      <= '0;
      end else begin
         cfg_ff        <= cfg_in;
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         chan_index_ff <= chan_index_in;
         fire_state_ff <= fire_state_in;
         if (stage_fire) begin
            last_edge_ff <= edge_ff;
            have_last_ff <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         edge_ff <= req_tdata[WIDTH_W-1:0];
      end
      if (stage_fire && chan_write) begin
         widths_ff[chan_index_ff[CHAN_SEL_W-1:0]] <= diff;
      end
      if (stage_fire && frame_done) begin
         frame_ff <= frame_eval;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {
      (RSP_DATA_W - RSP_FIELDS_W)'(0),
      frame_ff.fire_right,
      frame_ff.fire_left,
      frame_ff.zone_b,
      frame_ff.zone_a,
      frame_ff.drive_mode,
      frame_ff.switch_c_pos,
      frame_ff.switch_b_pos,
      frame_ff.stick_b_y,
      frame_ff.stick_b_x,
      frame_ff.stick_a_y,
      frame_ff.stick_a_x
   };

   // a finished frame always parks the counter and loads the result register
   a_frame_done_idles: assert property (@(posedge clock) disable iff (reset)
      stage_fire && frame_done |=> chan_index_ff == CHAN_IDLE && rsp_valid_ff)
      else $error("frame completion did not park the counter or load a result");

   // a new result only ever follows a completed frame
   a_result_from_frame: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(stage_fire && frame_done))
      else $error("result appeared without a completed frame");

   // fire flags only in drive mode 2
   a_fire_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (frame_ff.fire_left || frame_ff.fire_right)
         |-> frame_ff.drive_mode == MODE_UP_DOWN)
      else $error("fire flag outside drive mode 2");

   // a held edge is neither lost nor overwritten while the result stalls
   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !stage_fire |=> in_valid_ff && $stable(edge_ff))
      else $error("input register changed while stalled");

endmodule
